// ===== rtl/guide_pulse_correction_macros.svh =====
// ----------------------------------------------------------------------------
// guide_pulse_correction_macros.svh
// Assertion macros used by the guide pulse correction checker.
// ----------------------------------------------------------------------------
`ifndef GUIDE_PULSE_CORRECTION_MACROS_SVH
`define GUIDE_PULSE_CORRECTION_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define GPC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen outside reset.
`define GPC_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/gpc_pkg.sv =====
// ----------------------------------------------------------------------------
// gpc_pkg
// Widths, register codes and shared types of the guide pulse correction block.
// ----------------------------------------------------------------------------
package gpc_pkg;

    // Field widths
    localparam int DriftW   = 16;   // drift, Q7.8 pixels
    localparam int TrigW    = 16;   // orientation cos/sin, Q1.14
    localparam int GainW    = 16;   // gain, Q12.4 ms per pixel
    localparam int PulseW   = 13;   // pulse and maximum, whole ms
    localparam int MinW     = 10;   // minimum pulse, whole ms
    localparam int CfgDataW = 16;   // widest register
    localparam int RegIdxW  = 3;    // eight registers

    // Datapath widths
    localparam int ProdW    = DriftW + TrigW;     // one rotation product
    localparam int SumW     = ProdW + 1;          // rotated drift, Q.22
    localparam int MagW     = ProdW;              // |rotated drift|
    localparam int ScaledW  = MagW + GainW;       // ms in Q.26
    localparam int FracBits = 26;
    localparam int MsW      = ScaledW - FracBits; // whole ms before limiting

    // Register indexes
    typedef enum logic [RegIdxW-1:0] {
        REG_ORIENT_COS = 3'd0,
        REG_ORIENT_SIN = 3'd1,
        REG_GAIN_WEST  = 3'd2,
        REG_GAIN_EAST  = 3'd3,
        REG_GAIN_NORTH = 3'd4,
        REG_GAIN_SOUTH = 3'd5,
        REG_PULSE_MAX  = 3'd6,
        REG_PULSE_MIN  = 3'd7
    } gpc_reg_t;

    // Configuration seen by the datapath
    typedef struct packed {
        logic signed [TrigW-1:0] orient_cos;
        logic signed [TrigW-1:0] orient_sin;
        logic [GainW-1:0]        gain_west;
        logic [GainW-1:0]        gain_east;
        logic [GainW-1:0]        gain_north;
        logic [GainW-1:0]        gain_south;
        logic [PulseW-1:0]       pulse_max_ms;
        logic [MinW-1:0]         pulse_min_ms;
    } gpc_cfg_t;

    // One rotated axis: direction and magnitude
    typedef struct packed {
        logic            pos;
        logic            neg;
        logic [MagW-1:0] mag;
    } gpc_axis_t;

endpackage

// ===== rtl/gpc_if.sv =====
// ----------------------------------------------------------------------------
// gpc_if
// Valid/ready channels for drift items in and pulse items out.
// ----------------------------------------------------------------------------
interface gpc_drift_if
    import gpc_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [DriftW-1:0] drift_x;
    logic signed [DriftW-1:0] drift_y;

    modport source (output valid, output drift_x, output drift_y, input ready);
    modport sink   (input valid, input drift_x, input drift_y, output ready);
endinterface

interface gpc_pulse_if
    import gpc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [PulseW-1:0] pulse_west;
    logic [PulseW-1:0] pulse_east;
    logic [PulseW-1:0] pulse_north;
    logic [PulseW-1:0] pulse_south;

    modport source (output valid, output pulse_west, output pulse_east,
                    output pulse_north, output pulse_south, input ready);
    modport sink   (input valid, input pulse_west, input pulse_east,
                    input pulse_north, input pulse_south, output ready);
endinterface

// ===== rtl/gpc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// gpc_cfg_regs
// Configuration register file written through a plain write port.
// ----------------------------------------------------------------------------
module gpc_cfg_regs
    import gpc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [RegIdxW-1:0]  wr_index,
    input  logic [CfgDataW-1:0] wr_data,
    output gpc_cfg_t            cfg
);

    gpc_cfg_t cfg_reg;
    gpc_cfg_t cfg_next;

    // Decode the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_ORIENT_COS: cfg_next.orient_cos   = wr_data;
                REG_ORIENT_SIN: cfg_next.orient_sin   = wr_data;
                REG_GAIN_WEST:  cfg_next.gain_west    = wr_data;
                REG_GAIN_EAST:  cfg_next.gain_east    = wr_data;
                REG_GAIN_NORTH: cfg_next.gain_north   = wr_data;
                REG_GAIN_SOUTH: cfg_next.gain_south   = wr_data;
                REG_PULSE_MAX:  cfg_next.pulse_max_ms = wr_data[PulseW-1:0];
                REG_PULSE_MIN:  cfg_next.pulse_min_ms = wr_data[MinW-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers; orientation resets to zero degrees
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.orient_cos   <= TrigW'(16384);
            cfg_reg.orient_sin   <= '0;
            cfg_reg.gain_west    <= '0;
            cfg_reg.gain_east    <= '0;
            cfg_reg.gain_north   <= '0;
            cfg_reg.gain_south   <= '0;
            cfg_reg.pulse_max_ms <= '0;
            cfg_reg.pulse_min_ms <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/gpc_rotate.sv =====
// ----------------------------------------------------------------------------
// gpc_rotate
// Two stages: rotation products, then RA/DEC sums with sign and magnitude.
// ----------------------------------------------------------------------------
module gpc_rotate
    import gpc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [DriftW-1:0] drift_x,
    input  logic signed [DriftW-1:0] drift_y,
    input  logic signed [TrigW-1:0]  orient_cos,
    input  logic signed [TrigW-1:0]  orient_sin,
    output logic                     out_valid,
    input  logic                     out_ready,
    output gpc_axis_t                ra,
    output gpc_axis_t                de
);

    logic                    v1_reg;
    logic                    v2_reg;
    logic                    ready1;
    logic                    ready2;
    logic signed [ProdW-1:0] xc_reg;
    logic signed [ProdW-1:0] ys_reg;
    logic signed [ProdW-1:0] yc_reg;
    logic signed [ProdW-1:0] xs_reg;
    logic signed [ProdW-1:0] xc_next;
    logic signed [ProdW-1:0] ys_next;
    logic signed [ProdW-1:0] yc_next;
    logic signed [ProdW-1:0] xs_next;
    logic signed [SumW-1:0]  ra_sum;
    logic signed [SumW-1:0]  de_sum;
    logic signed [SumW-1:0]  ra_neg_sum;
    logic signed [SumW-1:0]  de_neg_sum;
    gpc_axis_t               ra_reg;
    gpc_axis_t               de_reg;
    gpc_axis_t               ra_next;
    gpc_axis_t               de_next;

    // A stage takes a new item when empty or when its item moves on
    assign ready2   = !v2_reg || out_ready;
    assign ready1   = !v1_reg || ready2;
    assign in_ready = ready1;

    // Stage 1: four 16x16 products
    assign xc_next = drift_x * orient_cos;
    assign ys_next = drift_y * orient_sin;
    assign yc_next = drift_y * orient_cos;
    assign xs_next = drift_x * orient_sin;

    // Stage 2: exact sums, sign and magnitude
    assign ra_sum     = SumW'(xc_reg) + SumW'(ys_reg);
    assign de_sum     = SumW'(yc_reg) - SumW'(xs_reg);
    assign ra_neg_sum = -ra_sum;
    assign de_neg_sum = -de_sum;

    always_comb
    begin
        ra_next.neg = ra_sum[SumW-1];
        ra_next.pos = !ra_sum[SumW-1] && (ra_sum != '0);
        ra_next.mag = ra_sum[SumW-1] ? ra_neg_sum[MagW-1:0] : ra_sum[MagW-1:0];
        de_next.neg = de_sum[SumW-1];
        de_next.pos = !de_sum[SumW-1] && (de_sum != '0);
        de_next.mag = de_sum[SumW-1] ? de_neg_sum[MagW-1:0] : de_sum[MagW-1:0];
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= in_valid;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    // Load payload only when an item moves in
    always_ff @(posedge clk)
    begin
        if (in_valid && ready1)
        begin
            xc_reg <= xc_next;
            ys_reg <= ys_next;
            yc_reg <= yc_next;
            xs_reg <= xs_next;
        end
        if (v1_reg && ready2)
        begin
            ra_reg <= ra_next;
            de_reg <= de_next;
        end
    end

    assign out_valid = v2_reg;
    assign ra        = ra_reg;
    assign de        = de_reg;

endmodule

// ===== rtl/gpc_scale.sv =====
// ----------------------------------------------------------------------------
// gpc_scale
// Two stages: gain multiply to whole ms, then clamp, suppress and steer.
// ----------------------------------------------------------------------------
module gpc_scale
    import gpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  gpc_cfg_t          cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  gpc_axis_t         ra,
    input  gpc_axis_t         de,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [PulseW-1:0] pulse_west,
    output logic [PulseW-1:0] pulse_east,
    output logic [PulseW-1:0] pulse_north,
    output logic [PulseW-1:0] pulse_south
);

    // Clamp to the maximum, then drop pulses under the minimum
    function automatic logic [PulseW-1:0] shape_ms(
        input logic [MsW-1:0]    ms,
        input logic [PulseW-1:0] max_ms,
        input logic [MinW-1:0]   min_ms
    );
        logic [PulseW-1:0] lim;
        lim = (ms > MsW'(max_ms)) ? max_ms : ms[PulseW-1:0];
        return (lim < PulseW'(min_ms)) ? '0 : lim;
    endfunction

    logic               v3_reg;
    logic               v4_reg;
    logic               ready3;
    logic               ready4;
    logic [GainW-1:0]   gain_ra;
    logic [GainW-1:0]   gain_de;
    logic [ScaledW-1:0] prod_ra;
    logic [ScaledW-1:0] prod_de;
    logic [MsW-1:0]     ra_ms_reg;
    logic [MsW-1:0]     de_ms_reg;
    logic               ra_pos_reg;
    logic               ra_neg_reg;
    logic               de_pos_reg;
    logic               de_neg_reg;
    logic [PulseW-1:0]  ra_shaped;
    logic [PulseW-1:0]  de_shaped;
    logic [PulseW-1:0]  west_reg;
    logic [PulseW-1:0]  east_reg;
    logic [PulseW-1:0]  north_reg;
    logic [PulseW-1:0]  south_reg;

    assign ready4   = !v4_reg || out_ready;
    assign ready3   = !v3_reg || ready4;
    assign in_ready = ready3;

    // Stage 3: pick the gain by direction and scale the magnitude
    assign gain_ra = ra.pos ? cfg.gain_west  : cfg.gain_east;
    assign gain_de = de.pos ? cfg.gain_south : cfg.gain_north;
    assign prod_ra = ra.mag * gain_ra;
    assign prod_de = de.mag * gain_de;

    // Stage 4: limit, then steer to the driven direction
    assign ra_shaped = shape_ms(ra_ms_reg, cfg.pulse_max_ms, cfg.pulse_min_ms);
    assign de_shaped = shape_ms(de_ms_reg, cfg.pulse_max_ms, cfg.pulse_min_ms);

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (ready3)
            begin
                v3_reg <= in_valid;
            end
            if (ready4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // Load payload only when an item moves in
    always_ff @(posedge clk)
    begin
        if (in_valid && ready3)
        begin
            ra_ms_reg  <= prod_ra[ScaledW-1:FracBits];
            de_ms_reg  <= prod_de[ScaledW-1:FracBits];
            ra_pos_reg <= ra.pos;
            ra_neg_reg <= ra.neg;
            de_pos_reg <= de.pos;
            de_neg_reg <= de.neg;
        end
        if (v3_reg && ready4)
        begin
            west_reg  <= ra_pos_reg ? ra_shaped : '0;
            east_reg  <= ra_neg_reg ? ra_shaped : '0;
            south_reg <= de_pos_reg ? de_shaped : '0;
            north_reg <= de_neg_reg ? de_shaped : '0;
        end
    end

    assign out_valid   = v4_reg;
    assign pulse_west  = west_reg;
    assign pulse_east  = east_reg;
    assign pulse_north = north_reg;
    assign pulse_south = south_reg;

endmodule

// ===== rtl/guide_pulse_correction.sv =====
// ----------------------------------------------------------------------------
// guide_pulse_correction
// Turns one star drift item into west/east/north/south guide pulse lengths.
// ----------------------------------------------------------------------------
// Usage:
//   drift  : valid/ready sink, one item is a drift_x/drift_y pair (Q7.8 px).
//   pulse  : valid/ready source, one item per drift item, four pulse lengths
//            in whole ms; at most one of west/east and of north/south is set.
//   wr_*   : register writes (orientation, gains, limits), taken on any
//            clock with wr_en high; write only while no item is in flight.
// Pipeline: an accepted drift item passes the products, RA/DEC sums, gain
//   multiply, and limit and steer stages in that order; each stage is one
//   register.
// Throughput: one item per cycle; drift.ready is high whenever pulse.ready
//   is high or any stage is empty.
// Reset: all stages empty, orientation at zero degrees, gains and limits
//   zero.
// Stall: while pulse.ready is low the output item holds; earlier stages
//   keep filling until the pipeline is full, then drift.ready drops.
// ----------------------------------------------------------------------------
module guide_pulse_correction
    import gpc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [RegIdxW-1:0]  wr_index,
    input  logic [CfgDataW-1:0] wr_data,
    gpc_drift_if.sink           drift,
    gpc_pulse_if.source         pulse
);

    gpc_cfg_t  cfg;
    logic      mid_valid;
    logic      mid_ready;
    gpc_axis_t mid_ra;
    gpc_axis_t mid_de;

    // Register file
    gpc_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    // Rotate into RA/DEC
    gpc_rotate u_rotate (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (drift.valid),
        .in_ready   (drift.ready),
        .drift_x    (drift.drift_x),
        .drift_y    (drift.drift_y),
        .orient_cos (cfg.orient_cos),
        .orient_sin (cfg.orient_sin),
        .out_valid  (mid_valid),
        .out_ready  (mid_ready),
        .ra         (mid_ra),
        .de         (mid_de)
    );

    // Scale and limit the pulses
    gpc_scale u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (mid_valid),
        .in_ready    (mid_ready),
        .ra          (mid_ra),
        .de          (mid_de),
        .out_valid   (pulse.valid),
        .out_ready   (pulse.ready),
        .pulse_west  (pulse.pulse_west),
        .pulse_east  (pulse.pulse_east),
        .pulse_north (pulse.pulse_north),
        .pulse_south (pulse.pulse_south)
    );

endmodule

// ===== rtl/gpc_checker.sv =====
// ----------------------------------------------------------------------------
// gpc_checker
// Port-level checks of the guide pulse correction block.
// ----------------------------------------------------------------------------
`include "guide_pulse_correction_macros.svh"

module gpc_checker
    import gpc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [PulseW-1:0] pulse_west,
    input logic [PulseW-1:0] pulse_east,
    input logic [PulseW-1:0] pulse_north,
    input logic [PulseW-1:0] pulse_south
);

    // A stalled output item holds
    `GPC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(pulse_west) && $stable(pulse_east) && $stable(pulse_north) && $stable(pulse_south), "stalled pulse item changed")

    // Only one direction per axis is driven
    `GPC_NEVER(a_ra_one_side, out_valid && (pulse_west != '0) && (pulse_east != '0), "west and east both driven")
    `GPC_NEVER(a_de_one_side, out_valid && (pulse_north != '0) && (pulse_south != '0), "north and south both driven")

    // A free-flowing output never throttles the input
    `GPC_ASSERT(a_no_throttle, out_ready |-> in_ready, "drift stalled while pulse side is ready")

    // Every accepted item shows up at the output when nothing stalls
    `GPC_ASSERT(a_latency, in_valid && in_ready ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid, "pulse item missing after four cycles")

endmodule

bind guide_pulse_correction gpc_checker u_gpc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (drift.valid),
    .in_ready    (drift.ready),
    .out_valid   (pulse.valid),
    .out_ready   (pulse.ready),
    .pulse_west  (pulse.pulse_west),
    .pulse_east  (pulse.pulse_east),
    .pulse_north (pulse.pulse_north),
    .pulse_south (pulse.pulse_south)
);

// ===== sim/guide_pulse_correction_tb.sv =====
// ----------------------------------------------------------------------------
// guide_pulse_correction_tb
// Self-checking bench for the guide pulse block. Drift items go in through a
// queue-fed driver and pulse items are checked by a monitor against an
// in-bench model of the rotate, scale, clamp and suppress path. Register
// settings change between phases while the pipeline is empty. Both channels
// idle at random, and the receiver stalls long enough to back up the input.
// ----------------------------------------------------------------------------
module guide_pulse_correction_tb;
    import gpc_pkg::*;

    localparam int          PhaseCount   = 12;
    localparam int          PhaseItems   = 128;
    localparam int          LongStall    = 200;
    localparam int unsigned WatchdogMax  = 5000;
    localparam int          ReportLimit  = 10;

    typedef struct packed {
        logic signed [DriftW-1:0] x;
        logic signed [DriftW-1:0] y;
    } drift_item_t;

    typedef struct packed {
        logic [PulseW-1:0] west;
        logic [PulseW-1:0] east;
        logic [PulseW-1:0] north;
        logic [PulseW-1:0] south;
    } pulse_item_t;

    logic                clk;
    logic                rst_n;
    logic                wr_en;
    logic [RegIdxW-1:0]  wr_index;
    logic [CfgDataW-1:0] wr_data;

    gpc_drift_if drift_ch ();
    gpc_pulse_if pulse_ch ();

    guide_pulse_correction u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .drift    (drift_ch),
        .pulse    (pulse_ch)
    );

    // Register image as the block should hold it
    gpc_cfg_t    cfg;
    drift_item_t pending_drifts[$];
    pulse_item_t expected_pulses[$];
    int          failures;
    int          results_seen;
    bit          src_no_gaps;
    bit          sink_no_gaps;

    // Scale one magnitude by its gain, drop the fraction, clamp, suppress
    function automatic logic [PulseW-1:0] limit_pulse(longint unsigned mag,
                                                      logic [GainW-1:0] gain);
        longint unsigned ms;
        ms = (mag * gain) >> FracBits;
        if (ms > cfg.pulse_max_ms)
            ms = cfg.pulse_max_ms;
        if (ms < cfg.pulse_min_ms)
            ms = 0;
        return ms[PulseW-1:0];
    endfunction

    // Rotate the drift into RA/DEC and steer each axis to one direction
    function automatic pulse_item_t predict_pulses(drift_item_t d);
        longint      ra;
        longint      de;
        pulse_item_t p;
        ra = longint'($signed(d.x)) * longint'($signed(cfg.orient_cos))
           + longint'($signed(d.y)) * longint'($signed(cfg.orient_sin));
        de = longint'($signed(d.y)) * longint'($signed(cfg.orient_cos))
           - longint'($signed(d.x)) * longint'($signed(cfg.orient_sin));
        p = '0;
        if (ra > 0)
            p.west = limit_pulse(longint'(ra), cfg.gain_west);
        else if (ra < 0)
            p.east = limit_pulse(longint'(-ra), cfg.gain_east);
        if (de > 0)
            p.south = limit_pulse(longint'(de), cfg.gain_south);
        else if (de < 0)
            p.north = limit_pulse(longint'(-de), cfg.gain_north);
        return p;
    endfunction

    // Mostly no gap, some short ones, a few long ones
    function automatic int unsigned pick_gap(bit no_gaps);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Favor drifts of a few pixels, with the full range now and then
    function automatic logic [DriftW-1:0] pick_drift();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return DriftW'(int'($urandom_range(0, 2047)) - 1024);
        if (r < 85)
            return DriftW'(int'($urandom_range(0, 16383)) - 8192);
        return DriftW'($urandom());
    endfunction

    function automatic logic [GainW-1:0] pick_gain();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 20)
            return '1;
        if (r < 60)
            return GainW'($urandom_range(1, 4095));
        return GainW'($urandom());
    endfunction

    task automatic count_failure();
        failures++;
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Drift driver: present the next pending item after a random gap
    int unsigned src_gap;
    always @(posedge clk)
    begin
        drift_item_t taken;
        drift_item_t nxt;
        if (!rst_n)
        begin
            drift_ch.valid <= 1'b0;
            src_gap = 0;
        end
        else
        begin
            if (drift_ch.valid && drift_ch.ready)
            begin
                taken.x = drift_ch.drift_x;
                taken.y = drift_ch.drift_y;
                expected_pulses.insert(expected_pulses.size(), predict_pulses(taken));
            end
            // Hold an offered item until it is taken
            if (!drift_ch.valid || drift_ch.ready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    drift_ch.valid <= 1'b0;
                end
                else if (pending_drifts.size() > 0)
                begin
                    nxt = pending_drifts.pop_front();
                    drift_ch.valid   <= 1'b1;
                    drift_ch.drift_x <= nxt.x;
                    drift_ch.drift_y <= nxt.y;
                    src_gap = pick_gap(src_no_gaps);
                end
                else
                begin
                    drift_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Pulse monitor: check each item against the oldest expectation
    int unsigned sink_gap;
    int unsigned stall_left;
    always @(posedge clk)
    begin
        pulse_item_t got;
        pulse_item_t want;
        if (!rst_n)
        begin
            pulse_ch.ready <= 1'b0;
            sink_gap   = 0;
            stall_left = 0;
        end
        else
        begin
            if (pulse_ch.valid && pulse_ch.ready)
            begin
                got.west  = pulse_ch.pulse_west;
                got.east  = pulse_ch.pulse_east;
                got.north = pulse_ch.pulse_north;
                got.south = pulse_ch.pulse_south;
                results_seen++;
                if (expected_pulses.size() == 0)
                begin
                    count_failure();
                    if (failures <= ReportLimit)
                        $display("unexpected pulse item: W=%0d E=%0d N=%0d S=%0d",
                                 got.west, got.east, got.north, got.south);
                end
                else
                begin
                    want = expected_pulses.pop_front();
                    if (got.west != want.west || got.east != want.east
                        || got.north != want.north || got.south != want.south)
                    begin
                        count_failure();
                        if (failures <= ReportLimit)
                            $display("pulse mismatch on item %0d: expected ",
                                     results_seen,
                                     "W=%0d E=%0d N=%0d S=%0d, ",
                                     want.west, want.east, want.north, want.south,
                                     "got W=%0d E=%0d N=%0d S=%0d",
                                     got.west, got.east, got.north, got.south);
                    end
                end
                // Back up the pipeline twice during the run
                if (results_seen == 400 || results_seen == 1200)
                    stall_left = LongStall;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                pulse_ch.ready <= 1'b0;
            end
            else if (sink_gap > 0)
            begin
                sink_gap--;
                pulse_ch.ready <= 1'b0;
            end
            else
            begin
                pulse_ch.ready <= 1'b1;
                sink_gap = pick_gap(sink_no_gaps);
            end
        end
    end

    // Watchdog: end the run when no item moves for too long
    int unsigned quiet_cycles;
    always @(posedge clk)
    begin
        if (!rst_n || (drift_ch.valid && drift_ch.ready)
            || (pulse_ch.valid && pulse_ch.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WatchdogMax)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic write_reg(gpc_reg_t idx, logic [CfgDataW-1:0] data);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        case (idx)
            REG_ORIENT_COS: cfg.orient_cos   = data[TrigW-1:0];
            REG_ORIENT_SIN: cfg.orient_sin   = data[TrigW-1:0];
            REG_GAIN_WEST:  cfg.gain_west    = data[GainW-1:0];
            REG_GAIN_EAST:  cfg.gain_east    = data[GainW-1:0];
            REG_GAIN_NORTH: cfg.gain_north   = data[GainW-1:0];
            REG_GAIN_SOUTH: cfg.gain_south   = data[GainW-1:0];
            REG_PULSE_MAX:  cfg.pulse_max_ms = data[PulseW-1:0];
            REG_PULSE_MIN:  cfg.pulse_min_ms = data[MinW-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(logic [CfgDataW-1:0] c, logic [CfgDataW-1:0] s,
                             logic [CfgDataW-1:0] gw, logic [CfgDataW-1:0] ge,
                             logic [CfgDataW-1:0] gn, logic [CfgDataW-1:0] gs,
                             logic [CfgDataW-1:0] mx, logic [CfgDataW-1:0] mn);
        write_reg(REG_ORIENT_COS, c);
        write_reg(REG_ORIENT_SIN, s);
        write_reg(REG_GAIN_WEST, gw);
        write_reg(REG_GAIN_EAST, ge);
        write_reg(REG_GAIN_NORTH, gn);
        write_reg(REG_GAIN_SOUTH, gs);
        write_reg(REG_PULSE_MAX, mx);
        write_reg(REG_PULSE_MIN, mn);
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    // Random orientation, gains and limits; spare upper data bits are noise
    task automatic load_random_config();
        real                 ang;
        int unsigned         r;
        logic [CfgDataW-1:0] c;
        logic [CfgDataW-1:0] s;
        logic [CfgDataW-1:0] mx;
        logic [CfgDataW-1:0] mn;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            ang = $urandom_range(0, 3599) * 3.14159265358979 / 1800.0;
            c = CfgDataW'(int'($cos(ang) * 16384.0));
            s = CfgDataW'(int'($sin(ang) * 16384.0));
        end
        else if (r < 80)
        begin
            case ($urandom_range(0, 3))
                0: begin c = 16'sd16384;  s = 16'sd0;      end
                1: begin c = 16'sd0;      s = 16'sd16384;  end
                2: begin c = -16'sd16384; s = 16'sd0;      end
                default: begin c = 16'sd0; s = -16'sd16384; end
            endcase
        end
        else
        begin
            c = CfgDataW'($urandom());
            s = CfgDataW'($urandom());
        end
        mx = CfgDataW'($urandom());
        r = $urandom_range(0, 99);
        if (r < 10)
            mx[PulseW-1:0] = '0;
        else if (r < 20)
            mx[PulseW-1:0] = '1;
        else if (r < 70)
            mx[PulseW-1:0] = PulseW'(5000);
        else
            mx[PulseW-1:0] = PulseW'($urandom_range(0, 5000));
        mn = CfgDataW'($urandom());
        r = $urandom_range(0, 99);
        if (r < 30)
            mn[MinW-1:0] = '0;
        else if (r < 40)
            mn[MinW-1:0] = '1;
        else
            mn[MinW-1:0] = MinW'($urandom_range(0, 300));
        configure(c, s, pick_gain(), pick_gain(), pick_gain(), pick_gain(), mx, mn);
    endtask

    task automatic push_drift(logic [DriftW-1:0] x, logic [DriftW-1:0] y);
        drift_item_t d;
        d.x = x;
        d.y = y;
        pending_drifts.insert(pending_drifts.size(), d);
    endtask

    // Wait until every offered item has come back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_drifts.size() != 0 || drift_ch.valid
               || expected_pulses.size() != 0);
    endtask

    // Stimulus
    initial
    begin
        rst_n             = 1'b0;
        wr_en             = 1'b0;
        wr_index          = '0;
        wr_data           = '0;
        drift_ch.valid    = 1'b0;
        drift_ch.drift_x  = '0;
        drift_ch.drift_y  = '0;
        pulse_ch.ready    = 1'b0;
        failures          = 0;
        results_seen      = 0;
        src_no_gaps       = 1'b0;
        sink_no_gaps      = 1'b0;
        cfg               = '0;
        cfg.orient_cos    = 16'sd16384;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: zero gains and limits give no pulses
        push_drift(16'h7FFF, 16'h7FFF);
        push_drift(16'h8000, 16'h8000);
        push_drift(16'h0100, 16'hFF00);
        wait_drained();

        // Straight orientation, distinct gain per direction
        configure(16'sd16384, 16'sd0, 16'h0100, 16'h0200, 16'h0080, 16'h0300,
                  16'd5000, 16'd10);
        push_drift(16'h0000, 16'h0000);     // zero drift on both axes
        push_drift(16'h0100, 16'h0000);     // west only
        push_drift(16'hFF00, 16'h0000);     // east only
        push_drift(16'h0000, 16'h0100);     // south only
        push_drift(16'h0000, 16'hFF00);     // north only
        push_drift(16'h7FFF, 16'h7FFF);     // clamps at the maximum
        push_drift(16'h8000, 16'h8000);
        push_drift(16'h7FFF, 16'h8000);
        push_drift(16'h8000, 16'h7FFF);
        push_drift(16'h0001, 16'h0001);     // below the minimum
        push_drift(16'hFFFF, 16'hFFFF);
        push_drift(16'h0080, 16'hFF80);     // half pixel, just under minimum
        push_drift(16'h00A0, 16'h0050);
        wait_drained();

        // Maximum below minimum suppresses every pulse
        configure(16'sd16384, 16'sd0, 16'h0100, 16'h0100, 16'h0100, 16'h0100,
                  16'd5, 16'd100);
        push_drift(16'h7FFF, 16'h8000);
        push_drift(16'h0040, 16'hFFC0);
        push_drift(16'h0000, 16'h0000);
        wait_drained();

        // Random phases; the first two use extreme settings
        for (int ph = 0; ph < PhaseCount; ph++)
        begin
            if (ph == 0)
                configure(16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          16'hFFFF, 16'hFFFF);
            else if (ph == 1)
                configure(16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          16'd5000, 16'd0);
            else
                load_random_config();
            src_no_gaps  = (ph == 2) || ($urandom_range(0, 3) == 0);
            sink_no_gaps = (ph == 2) || ($urandom_range(0, 3) == 0);
            for (int i = 0; i < PhaseItems; i++)
                push_drift(pick_drift(), pick_drift());
            wait_drained();
        end

        // Let stray items show up before the verdict
        repeat (8) @(posedge clk);
        if (expected_pulses.size() != 0)
            count_failure();
        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
